// ===== rtl/core/ek2k_pkg.sv =====
// Package for the EUC-KR to ISO-2022-KR converter: command type, queue status,
// output sequence steps and the fixed control bytes. No dependencies.
package ek2k_pkg;

	localparam logic [7:0] HIGH_BIT  = 8'h80;
	localparam logic [7:0] LOW7_MASK = 8'h7F;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_SO     = 8'h0E;
	localparam logic [7:0] CH_SI     = 8'h0F;

	// One output run, as classified by the front end
	typedef struct packed {
		logic       pair;    // double-byte pair, else plain byte
		logic       des;     // emit designator ESC $ ) C first
		logic       so;      // emit SO before the pair
		logic       si;      // emit SI before the plain byte
		logic [7:0] byte_a;  // plain byte, or lead with bit 7 cleared
		logic [6:0] byte_b;  // second byte of a pair, bit 7 cleared
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Output sequence positions of the back end
	typedef enum logic [2:0] {
		ST_ESC    = 3'd0,
		ST_DOLLAR = 3'd1,
		ST_RPAREN = 3'd2,
		ST_C      = 3'd3,
		ST_SO     = 3'd4,
		ST_SI     = 3'd5,
		ST_A      = 3'd6,
		ST_B      = 3'd7
	} step_t;

	// First step of a run
	function automatic step_t first_step(input cmd_t c);
		step_t s;
		if (c.des) begin
			s = ST_ESC;
		end else if (c.so) begin
			s = ST_SO;
		end else if (c.si) begin
			s = ST_SI;
		end else begin
			s = ST_A;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/euckr_to_iso2022kr_converter.sv =====
// Top level of the EUC-KR to ISO-2022-KR converter: front end, command queue
// and back end. Depends on ek2k_pkg, ek2k_front, ek2k_cmd_fifo, ek2k_back.
//
// Usage:
//   Input channel is a queue write port: in_byte is transferred at a clock
//   edge with push high and full low. Output channel is a queue read port:
//   while empty is low, out_byte and last_of_run show the oldest byte, and it
//   is transferred at an edge with pop high. last_of_run marks the final
//   byte caused by one input byte; a lead byte causes none.
//   An input byte that causes output passes the command queue and the back
//   end's run registers before its first byte enters the output register.
//   Throughput: one input byte per cycle while full is low; the back end
//   emits one output byte per cycle unless the receiver stalls, so a pair
//   gives two bytes plus up to five for designator and SO. The command queue
//   of QUEUE_DEPTH runs absorbs the difference; full rises when it fills.
//   Reset clears the lead, designator and mode state and empties the queue
//   and output register. When the receiver stalls, the output register holds
//   and the queue fills, after which full stalls the sender.
module euckr_to_iso2022kr_converter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import ek2k_pkg::*;

	q_stat_t q_stat;
	cmd_t    wr_cmd;
	cmd_t    rd_cmd;
	logic    q_push;
	logic    q_pop;

	ek2k_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (push),
		.in_byte (in_byte),
		.q_stat  (q_stat),
		.in_full (full),
		.q_push  (q_push),
		.q_cmd   (wr_cmd)
	);

	ek2k_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (wr_cmd),
		.pop    (q_pop),
		.rd_cmd (rd_cmd),
		.stat   (q_stat)
	);

	ek2k_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (rd_cmd),
		.q_stat      (q_stat),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	// Front never writes a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("command written to full queue");

	// Back never loads from an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command read from empty queue");

	// A plain run with SI ends on the byte after SI
	a_si_then_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && out_byte == CH_SI && !last_of_run)
		|=> (empty || last_of_run))
		else $error("SI not followed by last byte of run");

endmodule

// ===== rtl/core/ek2k_front.sv =====
// Front end of the converter: accepts input bytes, tracks lead and mode state
// and writes one command per output run to the queue. Uses ek2k_pkg.
module ek2k_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_push,
	input  logic [7:0]           in_byte,
	input  ek2k_pkg::q_stat_t    q_stat,
	output logic                 in_full,
	output logic                 q_push,
	output ek2k_pkg::cmd_t       q_cmd
);
	import ek2k_pkg::*;

	logic       lead_pending_q;
	logic [6:0] lead_q;
	logic       des_sent_q;
	logic       dbm_q;
	logic       accept;

	assign in_full = q_stat.full;
	assign accept  = in_push && !q_stat.full;

	// Classify the incoming byte into a command
	always_comb begin
		q_cmd        = '0;
		q_push       = 1'b0;
		if (lead_pending_q) begin
			q_cmd.pair   = 1'b1;
			q_cmd.des    = !des_sent_q;
			q_cmd.so     = !des_sent_q || !dbm_q;
			q_cmd.byte_a = {1'b0, lead_q};
			q_cmd.byte_b = in_byte[6:0];
			q_push       = accept;
		end else if ((in_byte & HIGH_BIT) == '0) begin
			q_cmd.si     = dbm_q;
			q_cmd.byte_a = in_byte;
			q_push       = accept;
		end
	end

	// Advance lead and mode state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_q         <= '0;
			des_sent_q     <= 1'b0;
			dbm_q          <= 1'b0;
		end else if (accept) begin
			if (lead_pending_q) begin
				lead_pending_q <= 1'b0;
				lead_q         <= '0;
				des_sent_q     <= 1'b1;
				dbm_q          <= 1'b1;
			end else if ((in_byte & HIGH_BIT) != '0) begin
				lead_pending_q <= 1'b1;
				lead_q         <= in_byte[6:0];
			end else begin
				dbm_q          <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/ek2k_cmd_fifo.sv =====
// Short command queue between front and back end of the converter.
// Register array with count; depends on ek2k_pkg.
module ek2k_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ek2k_pkg::cmd_t     wr_cmd,
	input  logic               pop,
	output ek2k_pkg::cmd_t     rd_cmd,
	output ek2k_pkg::q_stat_t  stat
);
	import ek2k_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_cmd     = slot_q[rd_ptr_q];

	// Write the slot on push
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ek2k_back.sv =====
// Back end of the converter: expands each queued command into its output
// bytes, one per unstalled cycle, to an output register. Uses ek2k_pkg.
module ek2k_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ek2k_pkg::cmd_t     q_cmd,
	input  ek2k_pkg::q_stat_t  q_stat,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               last_of_run
);
	import ek2k_pkg::*;

	logic       busy_q;
	cmd_t       cmd_q;
	step_t      step_q;
	step_t      step_d;
	logic       busy_d;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       advance;
	logic       emit;
	logic       run_end;
	logic [7:0] cur_byte;

	assign advance     = !out_valid_q || pop;
	assign emit        = busy_q && advance;
	assign run_end     = (step_q == ST_B) || (step_q == ST_A && !cmd_q.pair);
	assign q_pop       = !q_stat.empty && (!busy_q || (emit && run_end));
	assign empty       = !out_valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	// Select the byte of the current step
	always_comb begin
		case (step_q)
			ST_ESC:    cur_byte = CH_ESC;
			ST_DOLLAR: cur_byte = CH_DOLLAR;
			ST_RPAREN: cur_byte = CH_RPAREN;
			ST_C:      cur_byte = CH_C;
			ST_SO:     cur_byte = CH_SO;
			ST_SI:     cur_byte = CH_SI;
			ST_A:      cur_byte = cmd_q.byte_a;
			ST_B:      cur_byte = {1'b0, cmd_q.byte_b};
			default:   cur_byte = '0;
		endcase
	end

	// Next step and run load
	always_comb begin
		step_d = step_q;
		busy_d = busy_q;
		if (emit) begin
			case (step_q)
				ST_ESC:    step_d = ST_DOLLAR;
				ST_DOLLAR: step_d = ST_RPAREN;
				ST_RPAREN: step_d = ST_C;
				ST_C:      step_d = cmd_q.so ? ST_SO : ST_A;
				ST_SO:     step_d = ST_A;
				ST_SI:     step_d = ST_A;
				ST_A:      step_d = ST_B;
				ST_B:      step_d = ST_A;
				default:   step_d = ST_A;
			endcase
			if (run_end) begin
				busy_d = 1'b0;
			end
		end
		if (q_pop) begin
			step_d = first_step(q_cmd);
			busy_d = 1'b1;
		end
	end

	// Hold the current command
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_A;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= cur_byte;
			last_q <= run_end;
		end
	end

endmodule
